// ===== rtl/i2ctrm_pkg.sv =====
// Shared constants, command codes and interface types of the I2C target register map.
package i2ctrm_pkg;

  // Number of registers in the bank (1 to 256).
  localparam int unsigned REG_DEPTH = 256;
  localparam int unsigned BANK_AW   = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CMD_W     = 3;

  // Register depth as a 9-bit value, so that 256 compares cleanly with 8-bit indexes.
  localparam logic [8:0] REG_DEPTH_W9 = 9'(REG_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_BWRITE = 3'd1,
    CMD_BREAD  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_LREAD  = 3'd4,
    CMD_LWRITE = 3'd5
  } cmd_e;

  // One access to the register bank.
  typedef struct packed {
    logic               re;
    logic               we;
    logic [BANK_AW-1:0] addr;
    logic [DATA_W-1:0]  wdata;
  } bank_req_t;

endpackage

// ===== rtl/i2c_target_register_map.sv =====
// Top level of the I2C target register map: pointer logic, bank access and result register.
//
// The block is the register-map back end of an I2C target. Each input transaction on the
// in_* channel carries one bus event (start, written byte, requested byte, stop) or one
// local read or write of the register bank. Every input transaction yields exactly one
// output transaction on the out_* channel, in order.
// The register_count register is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while the block is idle, which the block itself does not enforce. It limits which
// register positions the bus may reach. An accepted transaction reads or writes the bank
// memory in its accept cycle; the registered read data and the fields held in the read
// stage then pass together into the output register, where the result is shown.
// The block accepts a new transaction only once the previous one has left the read stage.
// When the receiver stalls, the result stays in the output register unchanged; one further
// transaction may be accepted and waits in the read stage, and then in_stall_o is raised.
// Reset clears the offset, the position, the register count and all output and pipeline
// valid flags, and arms the first-byte flag. The bank reads as all zero after reset
// through per-entry written flags, so no clearing pass is needed.
module i2c_target_register_map_core
  import i2ctrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration.
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  // Input channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        local_index_i,
  // Output channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic [7:0]        access_index_o,
  output logic              access_done_o,
  output logic              report_valid_o,
  output logic [7:0]        report_offset_o,
  output logic [7:0]        report_length_o
);

  // Transaction state.
  logic [7:0] count_q;
  logic [7:0] offset_q, offset_d;
  logic [7:0] pos_q, pos_d;
  logic       expect_q, expect_d;

  // Read stage: holds the result fields while the bank read is in flight.
  logic       s1_valid_q;
  logic       s1_use_rd_q;
  logic [7:0] s1_aidx_q;
  logic       s1_adone_q;
  logic       s1_rvalid_q;
  logic [7:0] s1_roff_q;
  logic [7:0] s1_rlen_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_rd_q;
  logic [7:0] out_aidx_q;
  logic       out_adone_q;
  logic       out_rvalid_q;
  logic [7:0] out_roff_q;
  logic [7:0] out_rlen_q;

  logic              accept;
  logic              s1_move;
  cmd_e              cmd;
  logic              pos_in_range;
  logic              lidx_in_range;
  bank_req_t         bank_req;
  logic [DATA_W-1:0] bank_rdata;

  // Result fields of the accepted transaction, except the read data.
  logic       use_rd;
  logic [7:0] aidx;
  logic       adone;
  logic       rvalid;
  logic [7:0] roff;
  logic [7:0] rlen;

  assign cmd = cmd_e'(cmd_i);

  // The read stage moves on when the output register is empty or is being taken.
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // A bus position is in range when it is below both register_count and the bank depth.
  assign pos_in_range  = (pos_q < count_q) && ({1'b0, pos_q} < REG_DEPTH_W9);
  assign lidx_in_range = {1'b0, local_index_i} < REG_DEPTH_W9;

  always_comb begin
    offset_d       = offset_q;
    pos_d          = pos_q;
    expect_d       = expect_q;
    bank_req.re    = 1'b0;
    bank_req.we    = 1'b0;
    bank_req.addr  = pos_q[BANK_AW-1:0];
    bank_req.wdata = data_byte_i;
    use_rd         = 1'b0;
    aidx           = '0;
    adone          = 1'b0;
    rvalid         = 1'b0;
    roff           = '0;
    rlen           = '0;
    case (cmd)
      CMD_START: begin
        expect_d = 1'b1;
        pos_d    = offset_q;
      end
      CMD_BWRITE: begin
        if (expect_q) begin
          // The first byte after a start is the register offset.
          offset_d = data_byte_i;
          pos_d    = data_byte_i;
          expect_d = 1'b0;
        end else begin
          aidx = pos_q;
          if (pos_in_range) begin
            bank_req.we = 1'b1;
            pos_d       = pos_q + 8'd1;
            adone       = 1'b1;
          end
        end
      end
      CMD_BREAD: begin
        aidx = pos_q;
        if (pos_in_range) begin
          bank_req.re = 1'b1;
          use_rd      = 1'b1;
          pos_d       = pos_q + 8'd1;
          adone       = 1'b1;
        end
      end
      CMD_STOP: begin
        rvalid = 1'b1;
        roff   = offset_q;
        rlen   = pos_q - offset_q;
      end
      CMD_LREAD: begin
        bank_req.addr = local_index_i[BANK_AW-1:0];
        if (lidx_in_range) begin
          bank_req.re = 1'b1;
          use_rd      = 1'b1;
        end
      end
      CMD_LWRITE: begin
        bank_req.addr = local_index_i[BANK_AW-1:0];
        if (lidx_in_range) begin
          bank_req.we = 1'b1;
        end
      end
      default: begin
        // Unknown commands leave the state alone and give an all-zero result.
      end
    endcase
    if (!accept) begin
      offset_d    = offset_q;
      pos_d       = pos_q;
      expect_d    = expect_q;
      bank_req.re = 1'b0;
      bank_req.we = 1'b0;
    end
  end

  i2ctrm_bank u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bank_req),
    .rdata_o (bank_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      offset_q    <= '0;
      pos_q       <= '0;
      expect_q    <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      offset_q <= offset_d;
      pos_q    <= pos_d;
      expect_q <= expect_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_use_rd_q <= use_rd;
      s1_aidx_q   <= aidx;
      s1_adone_q  <= adone;
      s1_rvalid_q <= rvalid;
      s1_roff_q   <= roff;
      s1_rlen_q   <= rlen;
    end
    if (s1_move) begin
      out_rd_q     <= s1_use_rd_q ? bank_rdata : '0;
      out_aidx_q   <= s1_aidx_q;
      out_adone_q  <= s1_adone_q;
      out_rvalid_q <= s1_rvalid_q;
      out_roff_q   <= s1_roff_q;
      out_rlen_q   <= s1_rlen_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_rd_q;
  assign access_index_o  = out_aidx_q;
  assign access_done_o   = out_adone_q;
  assign report_valid_o  = out_rvalid_q;
  assign report_offset_o = out_roff_q;
  assign report_length_o = out_rlen_q;

endmodule

// ===== rtl/i2ctrm_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
module i2ctrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/i2ctrm_bank.sv =====
// Register bank: RAM plus per-entry written flags so that the bank reads as zero after reset.
module i2ctrm_bank
  import i2ctrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bank_req_t         req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [REG_DEPTH-1:0] written_q;
  logic [REG_DEPTH-1:0] written_d;
  logic                 rd_written_q;
  logic [DATA_W-1:0]    ram_rdata;

  i2ctrm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_DEPTH),
    .AW    (BANK_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (req_i.re),
    .we_i    (req_i.we),
    .addr_i  (req_i.addr),
    .wdata_i (req_i.wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    written_d = written_q;
    if (req_i.we) begin
      written_d[req_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      written_q <= written_d;
      if (req_i.re) begin
        rd_written_q <= written_q[req_i.addr];
      end
    end
  end

  // An entry never written since reset holds its reset value of zero.
  assign rdata_o = rd_written_q ? ram_rdata : '0;

endmodule
